// ===== src/mtsr_pkg.sv =====
`timescale 1ns / 1ps

package mtsr_pkg;

   localparam int STATE_WORDS = 624;
   localparam int MID_OFFSET  = 397;
   localparam int WORD_W      = 32;
   localparam int LIMIT_W     = 31;
   localparam int SEED_CNT_W  = $clog2(STATE_WORDS);

   localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_b0df;
   localparam logic [WORD_W-1:0] HIGH_BIT     = 32'h8000_0000;
   localparam logic [WORD_W-1:0] LOW_BITS     = 32'h7fff_ffff;
   localparam logic [WORD_W-1:0] SEED_MULT    = 32'd1812433253;
   localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd5489;
   localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
   localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;

   // fixed tap points of the state shift line
   typedef struct packed {
      logic [WORD_W-1:0] head;
      logic [WORD_W-1:0] next;
      logic [WORD_W-1:0] mid;
      logic [WORD_W-1:0] tail;
   } taps_type;

endpackage

// ===== src/mt19937_scaled_random.sv =====
`timescale 1ns / 1ps
// an accepted item is twisted and tempered into the s1 register, then scaled into rsp registers
// throughput: one item per cycle when rsp_ready is high, not seeding; one state shift per item
// reset: synchronous; afterwards the state line is seeded from 5489, req_ready low
// a seed write reseeds the state line, with req_ready low meanwhile
module mt19937_scaled_random (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [mtsr_pkg::LIMIT_W-1:0] req_limit,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [mtsr_pkg::LIMIT_W-1:0] rsp_scaled_value,
   output logic [mtsr_pkg::WORD_W-1:0]  rsp_raw_word,
   input  logic                         csr_we,
   input  logic [mtsr_pkg::WORD_W-1:0]  csr_wdata
);
   import mtsr_pkg::*;

   localparam int PROD_W = WORD_W + LIMIT_W;

   logic [WORD_W-1:0]     seed_ff,      seed_in;
   logic                  seeding_ff,   seeding_in;
   logic [SEED_CNT_W-1:0] seed_cnt_ff,  seed_cnt_in;
   logic                  s1_valid_ff,  s1_valid_in;
   logic [WORD_W-1:0]     s1_raw_ff,    s1_raw_in;
   logic [LIMIT_W-1:0]    s1_limit_ff,  s1_limit_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]     rsp_raw_ff,   rsp_raw_in;
   logic [LIMIT_W-1:0]    rsp_scaled_ff, rsp_scaled_in;

   taps_type          taps;
   logic              accept;
   logic              s1_move;
   logic              shift;
   logic [WORD_W-1:0] ins_word;
   logic [WORD_W-1:0] knuth_x;
   logic [WORD_W-1:0] knuth_prod;
   logic [WORD_W-1:0] knuth_word;
   logic [WORD_W-1:0] mix;
   logic [WORD_W-1:0] twist_word;
   logic [WORD_W-1:0] t1, t2, t3, t4;
   logic [PROD_W-1:0] scale_prod;

   mtsr_chain u_chain (
      .clock    (clock),
      .shift    (shift),
      .ins_word (ins_word),
      .taps     (taps)
   );

   always_comb begin
      s1_move   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
      req_ready = !seeding_ff && (!s1_valid_ff || s1_move);
      accept    = req_valid && req_ready;
      shift     = seeding_ff || accept;

      // knuth recurrence from the word last shifted in
      knuth_x    = taps.tail ^ (taps.tail >> 30);
      knuth_prod = knuth_x * SEED_MULT;
      knuth_word = knuth_prod + WORD_W'(seed_cnt_ff);

      // incremental twist: new word from the oldest, second and middle taps
      mix        = (taps.head & HIGH_BIT) | (taps.next & LOW_BITS);
      twist_word = taps.mid ^ (mix >> 1) ^ (taps.next[0] ? TWIST_MATRIX : '0);

      if (seeding_ff) begin
         ins_word = (seed_cnt_ff == '0) ? seed_ff : knuth_word;
      end else begin
         ins_word = twist_word;
      end

      t1 = twist_word ^ (twist_word >> 11);
      t2 = t1 ^ ((t1 << 7) & TEMPER_B);
      t3 = t2 ^ ((t2 << 15) & TEMPER_C);
      t4 = t3 ^ (t3 >> 18);

      seed_in     = seed_ff;
      seeding_in  = seeding_ff;
      seed_cnt_in = seed_cnt_ff;
      if (seeding_ff) begin
         seed_cnt_in = seed_cnt_ff + 1'b1;
         if (seed_cnt_ff == SEED_CNT_W'(STATE_WORDS - 1)) begin
            seeding_in  = 1'b0;
         end
      end
      if (csr_we) begin
         seed_in     = csr_wdata;
         seeding_in  = 1'b1;
         seed_cnt_in = '0;
      end

      s1_valid_in = s1_valid_ff;
      s1_raw_in   = s1_raw_ff;
      s1_limit_in = s1_limit_ff;
      if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_raw_in   = t4;
         s1_limit_in = req_limit;
      end

      scale_prod    = PROD_W'(s1_raw_ff) * PROD_W'(s1_limit_ff);
      rsp_valid_in  = rsp_valid_ff;
      rsp_raw_in    = rsp_raw_ff;
      rsp_scaled_in = rsp_scaled_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_move) begin
         rsp_valid_in  = 1'b1;
         rsp_raw_in    = s1_raw_ff;
         rsp_scaled_in = scale_prod[PROD_W-1:WORD_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= DEFAULT_SEED;
         seeding_ff   <= 1'b1;
         seed_cnt_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seed_ff      <= seed_in;
         seeding_ff   <= seeding_in;
         seed_cnt_ff  <= seed_cnt_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_raw_ff     <= s1_raw_in;
      s1_limit_ff   <= s1_limit_in;
      rsp_raw_ff    <= rsp_raw_in;
      rsp_scaled_ff <= rsp_scaled_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_raw_word     = rsp_raw_ff;
   assign rsp_scaled_value = rsp_scaled_ff;

endmodule

// ===== src/mtsr_cell.sv =====
`timescale 1ns / 1ps

module mtsr_cell (
   input  logic                       clock,
   input  logic                       shift,
   input  logic [mtsr_pkg::WORD_W-1:0] d,
   output logic [mtsr_pkg::WORD_W-1:0] q
);
   import mtsr_pkg::*;

   logic [WORD_W-1:0] word_ff;
   logic [WORD_W-1:0] word_in;

   always_comb begin
      word_in = shift ? d : word_ff;
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign q = word_ff;

endmodule

// ===== src/mtsr_chain.sv =====
`timescale 1ns / 1ps

module mtsr_chain (
   input  logic                        clock,
   input  logic                        shift,
   input  logic [mtsr_pkg::WORD_W-1:0] ins_word,
   output mtsr_pkg::taps_type          taps
);
   import mtsr_pkg::*;

   logic [WORD_W-1:0] cell_q [STATE_WORDS];

   // cell 0 holds the oldest word, new words enter at the tail
   for (genvar i = 0; i < STATE_WORDS; i++) begin : g_cell
      if (i == STATE_WORDS - 1) begin : g_tail
         mtsr_cell u_cell (
            .clock (clock),
            .shift (shift),
            .d     (ins_word),
            .q     (cell_q[i])
         );
      end else begin : g_body
         mtsr_cell u_cell (
            .clock (clock),
            .shift (shift),
            .d     (cell_q[i+1]),
            .q     (cell_q[i])
         );
      end
   end

   always_comb begin
      taps.head = cell_q[0];
      taps.next = cell_q[1];
      taps.mid  = cell_q[MID_OFFSET];
      taps.tail = cell_q[STATE_WORDS-1];
   end

endmodule

// ===== src/mtsr_checker.sv =====
`timescale 1ns / 1ps

module mtsr_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [mtsr_pkg::LIMIT_W-1:0] rsp_scaled_value,
   input logic [mtsr_pkg::WORD_W-1:0]  rsp_raw_word,
   input logic                         csr_we
);
   import mtsr_pkg::*;

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_raw_word)
                                  && $stable(rsp_scaled_value))
      else $error("result item changed while stalled");

   // limit is below 2^31, so the scaled value never exceeds half the word
   a_scale_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_scaled_value <= rsp_raw_word[WORD_W-1:1])
      else $error("scaled value out of range");

   // reseeding blocks new items
   a_seed_block: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !req_ready)
      else $error("item accepted during reseed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("output not empty after reset");

endmodule

bind mt19937_scaled_random mtsr_checker u_mtsr_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_scaled_value (rsp_scaled_value),
   .rsp_raw_word     (rsp_raw_word),
   .csr_we           (csr_we)
);
